// ----- hw/rtl/range_table_page_allocator_top_defines.svh -----
// Assertion macros shared by the range table page allocator.
`ifndef RANGE_TABLE_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define RANGE_TABLE_PAGE_ALLOCATOR_TOP_DEFINES_SVH
// Checks that a condition implies a consequence on the same edge.
`define RTPA_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence on the next edge.
`define RTPA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/rtpa_pkg.sv -----
// Package with shared constants and types of the range table page allocator.
`default_nettype none
package rtpa_pkg;
    localparam int FREE_SLOTS_DEF = 16;
    localparam int USED_SLOTS_DEF = 64;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [1:0] OP_FREE = 2'd0;
    localparam logic [1:0] OP_AT = 2'd1;
    localparam logic [1:0] OP_ANY = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } t_range;
endpackage
`default_nettype wire

// ----- hw/rtl/rtpa_table.sv -----
// Synchronous range table with one write port and one registered read port.
`default_nettype none
module rtpa_table #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire rtpa_pkg::t_range i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output rtpa_pkg::t_range      o_rdata
);
    rtpa_pkg::t_range r_mem [DEPTH];
    rtpa_pkg::t_range r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- hw/rtl/range_table_page_allocator_top.sv -----
// Top level of the range table page allocator: sequencer and table memories.
//
//  Channel  | Direction | tdata fields (low bit first)           | tuser
//  s_axis   | in        | op, range_start, range_length          | none
//  m_axis   | out       | granted_address, status                | none
//
// Op 0 and any dropped or unused op go from idle straight to the result.
// Op 1 reads the free table and, once the range lies inside a free entry,
// the used table, one entry per cycle.
// Op 2 repeats that check for each page address below the highest free end,
// starting at zero, until one fits.
// Reset is synchronous and clears the counts, the end and the sequencer.
// A pending result holds the sequencer until the m_axis transfer.
`default_nettype none
`include "range_table_page_allocator_top_defines.svh"
module range_table_page_allocator_top #(
    parameter int FREE_SLOTS = rtpa_pkg::FREE_SLOTS_DEF,
    parameter int USED_SLOTS = rtpa_pkg::USED_SLOTS_DEF,
    parameter int PAGE_BYTES = rtpa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op [1:0], range_start [33:2], range_length [65:34], zero [71:66]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // granted_address [31:0], status [33:32], zero [39:34]
    output logic [39:0]      m_axis_tdata
);
    localparam int FAW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int UAW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int FCW = $clog2(FREE_SLOTS + 1);
    localparam int UCW = $clog2(USED_SLOTS + 1);
    localparam int IW = (FCW > UCW) ? FCW : UCW;
    localparam logic [32:0] PAGE = 33'(PAGE_BYTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_USED = 3'd2;
    localparam logic [2:0] S_NEXT = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_op;
    logic [31:0] r_len;
    logic [32:0] r_addr;
    logic [FCW-1:0] r_fcnt;
    logic [UCW-1:0] r_ucnt;
    logic [31:0] r_hend;
    logic [IW-1:0] r_idx;
    logic        r_inside;
    logic        r_rvalid;
    logic [31:0] r_gaddr;
    logic [1:0]  r_status;

    logic [1:0]  in_op;
    logic [31:0] in_start, in_len;
    logic        acc_in;
    rtpa_pkg::t_range free_rd, used_rd, wr_rng;
    logic        free_we, used_we;
    logic [FAW-1:0] free_ra;
    logic [UAW-1:0] used_ra;
    logic [31:0] cur_s, cur_e, ent_e;
    logic        free_hit, used_hit, free_more, used_done, next_page, go_search;

    assign in_op = s_axis_tdata[1:0];
    assign in_start = s_axis_tdata[33:2];
    assign in_len = s_axis_tdata[65:34];
    assign s_axis_tready = (r_state == S_IDLE);
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {6'd0, r_status, r_gaddr};

    assign cur_s = r_addr[31:0];
    assign cur_e = cur_s + r_len;
    assign wr_rng.start = acc_in ? in_start : cur_s;
    assign wr_rng.length = acc_in ? in_len : r_len;
    assign free_we = acc_in && in_op == rtpa_pkg::OP_FREE && r_fcnt < FCW'(FREE_SLOTS);
    assign used_we = (r_state == S_USED) && !used_hit && used_done;
    assign free_ra = r_idx[FAW-1:0];
    assign used_ra = r_idx[UAW-1:0];

    rtpa_table #(.DEPTH(FREE_SLOTS), .AW(FAW)) u_free (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(r_fcnt[FAW-1:0]),
        .i_wdata(wr_rng), .i_raddr(free_ra), .o_rdata(free_rd)
    );
    rtpa_table #(.DEPTH(USED_SLOTS), .AW(UAW)) u_used (
        .i_clk(i_clk), .i_we(used_we), .i_waddr(r_ucnt[UAW-1:0]),
        .i_wdata(wr_rng), .i_raddr(used_ra), .o_rdata(used_rd)
    );

    assign ent_e = (r_state == S_FREE) ? free_rd.start + free_rd.length
                                       : used_rd.start + used_rd.length;

    // The entry read in the previous cycle sits one below r_idx.
    assign free_hit = r_rvalid && cur_s >= free_rd.start && cur_e <= ent_e;
    assign used_hit = r_rvalid && cur_s < ent_e && cur_e > used_rd.start;
    assign free_more = r_idx < IW'(r_fcnt);
    assign used_done = r_idx >= IW'(r_ucnt);
    assign next_page = r_op == rtpa_pkg::OP_ANY && r_addr + PAGE < {1'b0, r_hend};
    assign go_search = (in_op == rtpa_pkg::OP_AT || in_op == rtpa_pkg::OP_ANY)
        && r_ucnt < UCW'(USED_SLOTS) && !(in_op == rtpa_pkg::OP_ANY && r_hend == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc_in) n_state = go_search ? S_FREE : S_OUT;
            S_FREE: if (!(free_more && !free_hit)) begin
                n_state = (r_inside || free_hit) ? S_USED : S_NEXT;
            end
            S_USED: begin
                if (used_hit) n_state = S_NEXT;
                else if (used_done) n_state = S_OUT;
            end
            S_NEXT: n_state = next_page ? S_FREE : S_OUT;
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fcnt <= '0;
            r_ucnt <= '0;
            r_hend <= '0;
            r_rvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    r_op <= in_op;
                    r_len <= in_len;
                    r_gaddr <= '0;
                    r_status <= rtpa_pkg::ST_DONE;
                    r_idx <= '0;
                    r_inside <= 1'b0;
                    r_addr <= (in_op == rtpa_pkg::OP_AT) ? {1'b0, in_start} : '0;
                    if (in_op == rtpa_pkg::OP_FREE) begin
                        if (r_fcnt >= FCW'(FREE_SLOTS)) begin
                            r_status <= rtpa_pkg::ST_FULL;
                        end else begin
                            r_fcnt <= r_fcnt + FCW'(1);
                            if (in_start + in_len > r_hend) r_hend <= in_start + in_len;
                        end
                    end else if (in_op == rtpa_pkg::OP_AT || in_op == rtpa_pkg::OP_ANY) begin
                        if (r_ucnt >= UCW'(USED_SLOTS)) begin
                            r_status <= rtpa_pkg::ST_FULL;
                        end else if (in_op == rtpa_pkg::OP_ANY && r_hend == '0) begin
                            r_status <= rtpa_pkg::ST_NOFIT;
                        end
                    end
                end
                S_FREE: begin
                    if (free_hit) begin
                        r_inside <= 1'b1;
                    end
                    if (free_more && !free_hit) begin
                        r_idx <= r_idx + IW'(1);
                        r_rvalid <= 1'b1;
                    end else begin
                        r_idx <= '0;
                    end
                end
                S_USED: begin
                    if (!used_hit && used_done) begin
                        r_ucnt <= r_ucnt + UCW'(1);
                        r_gaddr <= cur_s;
                    end else if (!used_hit) begin
                        r_idx <= r_idx + IW'(1);
                        r_rvalid <= 1'b1;
                    end
                end
                S_NEXT: begin
                    r_idx <= '0;
                    r_inside <= 1'b0;
                    if (next_page) begin
                        r_addr <= r_addr + PAGE;
                    end else begin
                        r_status <= rtpa_pkg::ST_NOFIT;
                        r_gaddr <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    `RTPA_ASSERT_IMPL(a_out_state, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "out while ready")
    `RTPA_ASSERT_IMPL(a_fcnt_max, i_clk, i_rst_n, 1'b1, r_fcnt <= FCW'(FREE_SLOTS), "free count")
    `RTPA_ASSERT_IMPL(a_ucnt_max, i_clk, i_rst_n, 1'b1, r_ucnt <= UCW'(USED_SLOTS), "used count")
    `RTPA_ASSERT_IMPL(a_nofit_zero, i_clk, i_rst_n,
        m_axis_tvalid && r_status != rtpa_pkg::ST_DONE, r_gaddr == '0, "addr not zero")
endmodule
`default_nettype wire
